/* hdl/dal_pkg.sv */
// ----------------------------------------------------------------------------
// dal_pkg
// Shared types and constants for the device address allow list.
// ----------------------------------------------------------------------------
`default_nettype none

package dal_pkg;

	localparam int ENTRIES_DEF = 8;
	localparam int ADDR_W      = 48;
	localparam int FIELD_W     = 4;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_COUNT  = 2'd1,
		CMD_ADD    = 2'd2,
		CMD_REMOVE = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t              command;
		logic [ADDR_W-1:0] device_address;
		logic              random_address;
	} dal_req_t;

	typedef struct packed {
		logic               status;
		logic [FIELD_W-1:0] entry_count;
		logic [FIELD_W-1:0] slot;
	} dal_rsp_t;

	// one table entry as seen by the compare unit
	typedef struct packed {
		logic              en;
		logic              rnd;
		logic [ADDR_W-1:0] addr;
	} dal_entry_t;

endpackage

`default_nettype wire

/* hdl/dal_mem.sv */
// ----------------------------------------------------------------------------
// dal_mem
// Address store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dal_mem
	import dal_pkg::*;
#(
	parameter int DEPTH = ENTRIES_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire logic [ADDR_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [AW-1:0]     rd_addr,
	output      logic [ADDR_W-1:0] rd_data
);

	logic [ADDR_W-1:0] mem_q [DEPTH];
	logic [ADDR_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

/* hdl/dal_cmp.sv */
// ----------------------------------------------------------------------------
// dal_cmp
// Shared entry compare unit: free-slot test for add, key match for remove.
// ----------------------------------------------------------------------------
`default_nettype none

module dal_cmp
	import dal_pkg::*;
(
	input  wire cmd_t              cmd,
	input  wire logic [ADDR_W-1:0] key_addr,
	input  wire logic              key_rnd,
	input  wire dal_entry_t        entry,
	output      logic              hit
);

	logic key_match;

	assign key_match = entry.en && (entry.rnd == key_rnd) && (entry.addr == key_addr);

	always_comb begin
		unique case (cmd)
			CMD_ADD:    hit = !entry.en;
			CMD_REMOVE: hit = key_match;
			CMD_CLEAR:  hit = 1'b0;
			CMD_COUNT:  hit = 1'b0;
			default:    hit = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

/* hdl/device_address_allow_list_core.sv */
// ----------------------------------------------------------------------------
// device_address_allow_list_core
// Takes one item at a time: a new item is accepted only once the last one's
// result is registered, after a scan that walks the address store one entry
// per cycle through a single compare unit.
// Reset clears all enable and random flags at once; addresses are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module device_address_allow_list_core
	import dal_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output      logic     req_ready,
	input  wire dal_req_t req,
	output      logic     rsp_valid,
	input  wire logic     rsp_ready,
	output      dal_rsp_t rsp
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// control state
	state_t             state_q;
	logic [CW-1:0]      cnt_q;       // next entry to read, ENTRIES when done issuing
	logic               vld_s1;      // read data of idx_s1 arrives this cycle
	logic [AW-1:0]      idx_s1;
	logic               found_q;
	logic [AW-1:0]      hit_idx_q;
	logic [CW-1:0]      count_q;     // enabled entries before the command
	logic [ENTRIES-1:0] en_q;
	logic [ENTRIES-1:0] rnd_q;
	logic               rsp_valid_q;
	dal_rsp_t           rsp_q;

	// item key, held for the whole scan
	cmd_t              cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic              rnd_key_q;

	logic              accept;
	logic              issue;
	logic              rsp_free;
	logic              commit;
	logic              mem_wr;
	logic [ADDR_W-1:0] rd_data;
	dal_entry_t        entry;
	logic              hit;
	logic [31:0]       slot_w;
	logic [31:0]       none_w;
	logic [31:0]       cnt_inc_w;
	logic [31:0]       cnt_dec_w;
	logic [31:0]       cnt_w;
	dal_rsp_t          rsp_d;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign issue     = (state_q == ST_SCAN) && (cnt_q != CW'(ENTRIES));
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign commit    = (state_q == ST_FINISH) && rsp_free;
	assign mem_wr    = commit && (cmd_q == CMD_ADD) && found_q;

	// entry under test in the shared compare unit
	assign entry.en   = en_q[idx_s1];
	assign entry.rnd  = rnd_q[idx_s1];
	assign entry.addr = rd_data;

	// result field helpers, masked to the 4-bit fields
	assign slot_w    = 32'(hit_idx_q);
	assign none_w    = 32'(ENTRIES);
	assign cnt_w     = 32'(count_q);
	assign cnt_inc_w = cnt_w + 32'd1;
	assign cnt_dec_w = cnt_w - 32'd1;

	// result of the finished scan
	always_comb begin
		rsp_d.status      = 1'b0;
		rsp_d.slot        = none_w[FIELD_W-1:0];
		rsp_d.entry_count = cnt_w[FIELD_W-1:0];
		unique case (cmd_q)
			CMD_CLEAR: begin
				rsp_d.entry_count = '0;
			end
			CMD_COUNT: begin
			end
			CMD_ADD: begin
				if (found_q) begin
					rsp_d.slot        = slot_w[FIELD_W-1:0];
					rsp_d.entry_count = cnt_inc_w[FIELD_W-1:0];
				end else begin
					// table full
					rsp_d.status = 1'b1;
				end
			end
			CMD_REMOVE: begin
				// no match still reports success
				if (found_q) begin
					rsp_d.slot        = slot_w[FIELD_W-1:0];
					rsp_d.entry_count = cnt_dec_w[FIELD_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	dal_mem #(
		.DEPTH (ENTRIES),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr),
		.wr_addr (hit_idx_q),
		.wr_data (addr_q),
		.rd_en   (issue),
		.rd_addr (cnt_q[AW-1:0]),
		.rd_data (rd_data)
	);

	dal_cmp u_cmp (
		.cmd      (cmd_q),
		.key_addr (addr_q),
		.key_rnd  (rnd_key_q),
		.entry    (entry),
		.hit      (hit)
	);

	// key capture on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= req.command;
			addr_q    <= req.device_address;
			rnd_key_q <= req.random_address;
		end
	end

	// sequencer, flag table and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			found_q     <= 1'b0;
			hit_idx_q   <= '0;
			count_q     <= '0;
			en_q        <= '0;
			rnd_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			// read stage: address goes to the store, index follows the data
			vld_s1 <= issue;
			if (issue) begin
				idx_s1 <= cnt_q[AW-1:0];
				cnt_q  <= cnt_q + CW'(1);
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						cnt_q   <= '0;
						found_q <= 1'b0;
						count_q <= '0;
					end
				end
				ST_SCAN: begin
					// compare stage: count enabled entries, keep the lowest hit
					if (vld_s1) begin
						count_q <= count_q + CW'(entry.en);
						if (!found_q && hit) begin
							found_q   <= 1'b1;
							hit_idx_q <= idx_s1;
						end
					end
					if (!issue) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
						rsp_q   <= rsp_d;
						unique case (cmd_q)
							CMD_CLEAR: begin
								en_q  <= '0;
								rnd_q <= '0;
							end
							CMD_COUNT: begin
							end
							CMD_ADD: begin
								if (found_q) begin
									en_q[hit_idx_q]  <= 1'b1;
									rnd_q[hit_idx_q] <= rnd_key_q;
								end
							end
							CMD_REMOVE: begin
								if (found_q) begin
									en_q[hit_idx_q]  <= 1'b0;
									rnd_q[hit_idx_q] <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for device_address_allow_list_core. A directed table
// covers empty and full tables, duplicate adds, flag mismatches on remove,
// clear and the all-zero and all-one addresses. A long random run follows,
// biased so that adds fill the table and most removes hit a live entry. Every
// response is checked field by field against the row's expected values or an
// in-bench table model, with random idle gaps on request and response side.
// ----------------------------------------------------------------------------

module tb_top;
	import dal_pkg::*;

	localparam int ENTRIES      = ENTRIES_DEF;
	localparam int LATENCY      = ENTRIES + 3;
	localparam int RANDOM_ITEMS = 930;
	localparam int HOLD_AT_ITEM = 150;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_AT     = 500;
	localparam int CYCLE_LIMIT  = 400000;
	localparam logic [FIELD_W-1:0] SLOT_NONE = FIELD_W'(ENTRIES);
	localparam logic [ADDR_W-1:0]  ADDR_ONES = {ADDR_W{1'b1}};

	// one row of the directed table
	typedef struct {
		dal_req_t req;
		bit       typed;
		dal_rsp_t want;
	} stim_row_t;

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	dal_req_t req;
	logic     rsp_valid;
	logic     rsp_ready;
	dal_rsp_t rsp;

	// mirror of the allow list table
	bit                table_en   [ENTRIES];
	bit                table_rnd  [ENTRIES];
	logic [ADDR_W-1:0] table_addr [ENTRIES];

	// responses still owed by the block, oldest first
	dal_rsp_t          pending_rsp_q [$];
	stim_row_t         directed_rows [$];
	logic [ADDR_W-1:0] addr_pool [8];

	int  error_count;
	int  items_accepted;
	int  cycle_count;
	bit  rsp_hold_active;

	device_address_allow_list_core #(
		.ENTRIES(ENTRIES)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// clock and the single reset pulse
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// run limit, reckoned well above the slowest legal run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	// table update for one command, returns the response it causes
	function automatic dal_rsp_t apply_table_cmd(input dal_req_t r);
		dal_rsp_t res;
		int       hit;
		int       live;
		int       k;
		res.status = 1'b0;
		res.slot   = SLOT_NONE;
		hit        = -1;
		live       = 0;
		case (r.command)
			CMD_CLEAR: begin
				// addresses stay, only the flags drop
				for (k = 0; k < ENTRIES; k++) begin
					table_en[k]  = 1'b0;
					table_rnd[k] = 1'b0;
				end
			end
			CMD_ADD: begin
				// lowest free slot, duplicates allowed
				for (k = 0; k < ENTRIES; k++)
					if (hit < 0 && !table_en[k])
						hit = k;
				if (hit < 0) begin
					res.status = 1'b1;
				end else begin
					table_addr[hit] = r.device_address;
					table_rnd[hit]  = r.random_address;
					table_en[hit]   = 1'b1;
					res.slot        = FIELD_W'(hit);
				end
			end
			CMD_REMOVE: begin
				// lowest live entry with matching address and flag
				for (k = 0; k < ENTRIES; k++)
					if (hit < 0 && table_en[k] && table_rnd[k] == r.random_address
							&& table_addr[k] == r.device_address)
						hit = k;
				// a miss still reports success
				if (hit >= 0) begin
					table_en[hit]  = 1'b0;
					table_rnd[hit] = 1'b0;
					res.slot       = FIELD_W'(hit);
				end
			end
			default: begin
			end
		endcase
		for (k = 0; k < ENTRIES; k++)
			if (table_en[k])
				live++;
		res.entry_count = FIELD_W'(live);
		return res;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [ADDR_W-1:0] random_addr();
		return {16'($urandom), 32'($urandom)};
	endfunction

	// random command, biased toward adds and toward removes that hit
	function automatic dal_req_t pick_request();
		dal_req_t r;
		int       live_idx [$];
		int       pick;
		int       roll;
		int       k;
		roll             = $urandom_range(0, 99);
		r.random_address = 1'($urandom);
		r.device_address = ($urandom_range(0, 99) < 40) ? addr_pool[$urandom_range(0, 7)]
		                                                 : random_addr();
		if (roll < 6) begin
			r.command = CMD_CLEAR;
		end else if (roll < 18) begin
			r.command = CMD_COUNT;
		end else if (roll < 58) begin
			r.command = CMD_ADD;
		end else begin
			r.command = CMD_REMOVE;
			for (k = 0; k < ENTRIES; k++)
				if (table_en[k])
					live_idx.push_back(k);
			pick = $urandom_range(0, 99);
			if (live_idx.size() != 0 && pick < 75) begin
				k                = live_idx[$urandom_range(0, live_idx.size() - 1)];
				r.device_address = table_addr[k];
				// sometimes the right address with the wrong flag
				r.random_address = (pick < 60) ? table_rnd[k] : !table_rnd[k];
			end
		end
		return r;
	endfunction

	function automatic void dir_row(input cmd_t cmd, input logic [ADDR_W-1:0] addr,
			input logic rnd, input bit typed, input logic st = 1'b0,
			input int cnt = 0, input int slot = ENTRIES);
		stim_row_t row;
		row.req.command          = cmd;
		row.req.device_address   = addr;
		row.req.random_address   = rnd;
		row.typed                = typed;
		row.want.status          = st;
		row.want.entry_count     = FIELD_W'(cnt);
		row.want.slot            = FIELD_W'(slot);
		directed_rows.push_back(row);
	endfunction

	// offer one item, hold it until taken, then log what it should produce
	task automatic drive_request(input dal_req_t r, input bit typed, input dal_rsp_t want);
		dal_rsp_t predicted;
		@(negedge clk);
		req       <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_ready !== 1'b1);
		items_accepted++;
		predicted = apply_table_cmd(r);
		pending_rsp_q.push_back(typed ? want : predicted);
	endtask

	task automatic idle_request(input int gap);
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// request side
	initial begin
		dal_req_t r;
		dal_rsp_t none;
		int       k;
		req_valid      = 1'b0;
		req            = '0;
		error_count    = 0;
		items_accepted = 0;
		none           = '0;
		for (k = 0; k < ENTRIES; k++) begin
			table_en[k]   = 1'b0;
			table_rnd[k]  = 1'b0;
			table_addr[k] = '0;
		end
		addr_pool[0] = '0;
		addr_pool[1] = ADDR_ONES;
		for (k = 2; k < 8; k++)
			addr_pool[k] = random_addr();

		// directed table: empty table, duplicates, flag mismatch, full, clear
		dir_row(CMD_COUNT,  '0,               1'b0, 1'b1, 1'b0, 0, ENTRIES);
		dir_row(CMD_REMOVE, '0,               1'b0, 1'b1, 1'b0, 0, ENTRIES);
		dir_row(CMD_ADD,    '0,               1'b0, 1'b1, 1'b0, 1, 0);
		dir_row(CMD_ADD,    ADDR_ONES,        1'b1, 1'b1, 1'b0, 2, 1);
		dir_row(CMD_ADD,    ADDR_ONES,        1'b1, 1'b1, 1'b0, 3, 2);
		dir_row(CMD_REMOVE, ADDR_ONES,        1'b0, 1'b1, 1'b0, 3, ENTRIES);
		dir_row(CMD_REMOVE, ADDR_ONES,        1'b1, 1'b1, 1'b0, 2, 1);
		dir_row(CMD_ADD,    48'h0123456789AB, 1'b0, 1'b1, 1'b0, 3, 1);
		dir_row(CMD_ADD,    48'hA5A5A5A5A5A5, 1'b1, 1'b0);
		dir_row(CMD_ADD,    48'h800000000001, 1'b0, 1'b0);
		dir_row(CMD_ADD,    48'h7FFFFFFFFFFE, 1'b1, 1'b0);
		dir_row(CMD_ADD,    48'hFEDCBA987654, 1'b0, 1'b0);
		dir_row(CMD_ADD,    48'h000000000001, 1'b1, 1'b0);
		dir_row(CMD_ADD,    48'h5A5A5A5A5A5A, 1'b0, 1'b1, 1'b1, ENTRIES, ENTRIES);
		dir_row(CMD_COUNT,  '0,               1'b1, 1'b1, 1'b0, ENTRIES, ENTRIES);
		dir_row(CMD_REMOVE, '0,               1'b0, 1'b1, 1'b0, ENTRIES - 1, 0);
		dir_row(CMD_CLEAR,  ADDR_ONES,        1'b1, 1'b1, 1'b0, 0, ENTRIES);
		dir_row(CMD_COUNT,  '0,               1'b0, 1'b1, 1'b0, 0, ENTRIES);
		dir_row(CMD_REMOVE, ADDR_ONES,        1'b1, 1'b1, 1'b0, 0, ENTRIES);
		dir_row(CMD_ADD,    48'hAAAAAAAAAAAA, 1'b1, 1'b1, 1'b0, 1, 0);
		dir_row(CMD_ADD,    48'h555555555555, 1'b0, 1'b1, 1'b0, 2, 1);
		dir_row(CMD_REMOVE, 48'h555555555555, 1'b0, 1'b0);

		wait (arst_n === 1'b1);

		foreach (directed_rows[i]) begin
			drive_request(directed_rows[i].req, directed_rows[i].typed,
				directed_rows[i].want);
			idle_request(pick_idle_gap());
		end

		// let the directed part drain before the random run
		idle_request(1);
		while (pending_rsp_q.size() != 0)
			@(posedge clk);

		for (k = 0; k < RANDOM_ITEMS; k++) begin
			r = pick_request();
			drive_request(r, 1'b0, none);
			// sender pauses once until every response is back
			if (k == DRAIN_AT) begin
				idle_request(1);
				while (pending_rsp_q.size() != 0)
					@(posedge clk);
			end else if (!rsp_hold_active && (k % 200) >= 40) begin
				// back-to-back stretches, and back-to-back during the hold-off
				idle_request(pick_idle_gap());
			end
		end
		@(negedge clk);
		req_valid <= 1'b0;

		while (pending_rsp_q.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);

		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// response side: random stalls, calm stretches and one long hold-off
	initial begin
		int  stall_left;
		int  calm_left;
		bit  hold_done;
		rsp_ready       = 1'b0;
		rsp_hold_active = 1'b0;
		stall_left      = 0;
		calm_left       = 0;
		hold_done       = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && items_accepted >= HOLD_AT_ITEM) begin
				// block fills up and must push back on requests
				rsp_hold_active = 1'b1;
				rsp_ready      <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rsp_hold_active = 1'b0;
				hold_done       = 1'b1;
			end else if (stall_left > 0) begin
				rsp_ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_ready <= 1'b1;
				if (calm_left > 0)
					calm_left--;
				else if ($urandom_range(0, 99) < 5)
					calm_left = $urandom_range(40, 120);
				else
					stall_left = pick_idle_gap();
			end
		end
	end

	// compare each taken response with the oldest one owed
	always @(posedge clk) begin
		dal_rsp_t owed;
		if (arst_n && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
			if (pending_rsp_q.size() == 0) begin
				report_mismatch($sformatf("unexpected item status=%0b count=%0d slot=%0d",
					rsp.status, rsp.entry_count, rsp.slot));
			end else begin
				owed = pending_rsp_q.pop_front();
				if (rsp.status !== owed.status)
					report_mismatch($sformatf("status got %b want %b",
						rsp.status, owed.status));
				if (rsp.entry_count !== owed.entry_count)
					report_mismatch($sformatf("entry_count got %0d want %0d",
						rsp.entry_count, owed.entry_count));
				if (rsp.slot !== owed.slot)
					report_mismatch($sformatf("slot got %0d want %0d",
						rsp.slot, owed.slot));
			end
		end
	end

endmodule
